@@ sv/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, widths, constants and helper functions for the
// quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 13;
	localparam int ACC_FRAC        = 30;

	localparam int Q_W   = 16;              // quaternion component
	localparam int S_W   = 33;              // sum of squares, unsigned
	localparam int T_W   = 33;              // test value, signed
	localparam int ARG_W = 34;              // atan2 arguments from the front end
	localparam int THR_W = 15;
	localparam int ANG_W = 17;              // output angle
	localparam int CW    = 40;              // CORDIC x/y datapath
	localparam int AW    = 36;              // CORDIC angle accumulator

	localparam int DIV_BITS   = ACC_FRAC + 1;
	localparam int SQRT_STEPS = ACC_FRAC + 1;
	localparam int NW         = 2 * ACC_FRAC + 2;
	localparam int OUT_SH     = ACC_FRAC - ANGLE_FRAC_BITS;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(8176);

	localparam logic signed [AW-1:0] HALF_PI_ACC = AW'(64'sd1686629713);
	localparam logic signed [AW:0]   OUT_HALF    = (AW+1)'(1) << (OUT_SH - 1);
	localparam logic signed [AW:0]   OUT_MAX     = (AW+1)'(65535);
	localparam logic signed [AW:0]   OUT_MIN     = -(AW+1)'(65536);

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	typedef struct packed {
		logic  zero;
		pole_t pole;
	} tag_t;

	typedef struct packed {
		tag_t                 tag;
		logic                 t_neg;
		logic signed [CW-1:0] roll_y;
		logic signed [CW-1:0] roll_x;
		logic signed [CW-1:0] yaw_y;
		logic signed [CW-1:0] yaw_x;
	} side_t;

	// floor(atan(2^-i) * 2^30)
	function automatic logic signed [AW-1:0] atan_entry(input int i);
		logic [31:0] e;
		case (i)
			0: e = 32'd843314856;
			1: e = 32'd497837829;
			2: e = 32'd263043836;
			3: e = 32'd133525158;
			4: e = 32'd67021686;
			5: e = 32'd33543515;
			6: e = 32'd16775850;
			7: e = 32'd8388437;
			8: e = 32'd4194282;
			9: e = 32'd2097149;
			10: e = 32'd1048575;
			11: e = 32'd524287;
			12: e = 32'd262143;
			13: e = 32'd131071;
			14: e = 32'd65535;
			15: e = 32'd32767;
			16: e = 32'd16383;
			17: e = 32'd8191;
			18: e = 32'd4095;
			19: e = 32'd2047;
			20: e = 32'd1023;
			21: e = 32'd511;
			22: e = 32'd255;
			23: e = 32'd127;
			24: e = 32'd63;
			25: e = 32'd31;
			26: e = 32'd15;
			27: e = 32'd7;
			28: e = 32'd3;
			29: e = 32'd1;
			default: e = 32'd0;
		endcase
		return AW'(e);
	endfunction

	// round half up to the output format, then saturate
	function automatic logic [ANG_W-1:0] to_out(input logic signed [AW-1:0] acc);
		logic signed [AW:0] sum;
		logic signed [AW:0] r;
		sum = $signed({acc[AW-1], acc}) + OUT_HALF;
		r = sum >>> OUT_SH;
		if (r > OUT_MAX)
			r = OUT_MAX;
		if (r < OUT_MIN)
			r = OUT_MIN;
		return r[ANG_W-1:0];
	endfunction

endpackage

@@ sv/quaternion_to_euler.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Quaternion (Q2.14) to pitch/yaw/roll (Q4.13 rad) with pole detection.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)               | tuser
//  s_*      | in  | quat_x, quat_y, quat_z, quat_w   | -
//  m_*      | out | pitch_angle, yaw_angle, roll_ang | pole_case
//  cfg_*    | in  | singular_threshold (15 bit)      | -
//
// One transaction per cycle while the output is not held. Most of the
// latency comes from the bit-per-stage divider and square root ahead of
// the three parallel CORDIC pipelines. The whole pipeline advances
// together and freezes while the output holds a result that m_tready
// does not take. Reset clears all valid bits and loads the threshold
// with 0.499.
// ----------------------------------------------------------------------------
module quaternion_to_euler import qte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [55:0]       m_tdata,   // pitch_angle, yaw_angle, roll_angle, zero pad
	output logic [1:0]        m_tuser,   // pole_case
	input  logic              cfg_we,
	input  logic [THR_W-1:0]  cfg_wdata
);

	logic en;
	logic [THR_W-1:0] threshold_q;

	logic                fr_valid;
	logic [S_W-1:0]      fr_num, fr_den;
	side_t               fr_side;

	logic                dv_valid;
	logic [DIV_BITS-1:0] dv_quo;
	side_t               dv_side;

	logic                sq_valid;
	logic [DIV_BITS-1:0] sq_v;
	logic [ACC_FRAC:0]   sq_c;
	side_t               sq_side;

	logic signed [CW-1:0] pitch_y, pitch_x;
	logic                 cp_valid;
	logic signed [AW-1:0] zp, zy, zr;
	tag_t                 cp_tag;

	logic signed [AW-1:0] pitch_acc, yaw_acc, roll_acc;

	logic             out_valid_q;
	logic [ANG_W-1:0] pitch_q, yaw_q, roll_q;
	pole_t            pole_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= THR_RESET;
		else if (cfg_we)
			threshold_q <= cfg_wdata;
	end

	qte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.qx        ($signed(s_tdata[15:0])),
		.qy        ($signed(s_tdata[31:16])),
		.qz        ($signed(s_tdata[47:32])),
		.qw        ($signed(s_tdata[63:48])),
		.thr       (threshold_q),
		.out_valid (fr_valid),
		.num       (fr_num),
		.den       (fr_den),
		.side      (fr_side)
	);

	qte_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.num       (fr_num),
		.den       (fr_den),
		.side_in   (fr_side),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.side_out  (dv_side)
	);

	qte_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.v_in      (dv_quo),
		.side_in   (dv_side),
		.out_valid (sq_valid),
		.v_out     (sq_v),
		.c_out     (sq_c),
		.side_out  (sq_side)
	);

	// signed sine term carries the sign of the test value
	assign pitch_y = sq_side.t_neg ? -CW'(sq_v) : CW'(sq_v);
	assign pitch_x = CW'(sq_c);

	qte_cordic u_cordic_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.y_in      (pitch_y),
		.x_in      (pitch_x),
		.tag_in    (sq_side.tag),
		.out_valid (cp_valid),
		.angle     (zp),
		.tag_out   (cp_tag)
	);

	qte_cordic u_cordic_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.y_in      (sq_side.yaw_y),
		.x_in      (sq_side.yaw_x),
		.tag_in    (sq_side.tag),
		.out_valid (),
		.angle     (zy),
		.tag_out   ()
	);

	qte_cordic u_cordic_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.y_in      (sq_side.roll_y),
		.x_in      (sq_side.roll_x),
		.tag_in    (sq_side.tag),
		.out_valid (),
		.angle     (zr),
		.tag_out   ()
	);

	always_comb begin
		pitch_acc = zp;
		yaw_acc   = zy;
		roll_acc  = zr;
		unique case (cp_tag.pole)
			POLE_NORTH: begin
				roll_acc  = zr <<< 1;
				pitch_acc = HALF_PI_ACC;
				yaw_acc   = '0;
			end
			POLE_SOUTH: begin
				roll_acc  = -(zr <<< 1);
				pitch_acc = -HALF_PI_ACC;
				yaw_acc   = '0;
			end
			default: ;
		endcase
		if (cp_tag.zero) begin
			pitch_acc = '0;
			yaw_acc   = '0;
			roll_acc  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= cp_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q <= to_out(pitch_acc);
			yaw_q   <= to_out(yaw_acc);
			roll_q  <= to_out(roll_acc);
			pole_q  <= cp_tag.zero ? POLE_NONE : cp_tag.pole;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, roll_q, yaw_q, pitch_q};
	assign m_tuser  = pole_q;

endmodule

@@ sv/qte_front.sv @@
// ----------------------------------------------------------------------------
// qte_front
// Products, sums, pole test against the threshold and atan2 argument setup.
// Four register stages.
// ----------------------------------------------------------------------------
module qte_front import qte_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [Q_W-1:0]   qx,
	input  logic signed [Q_W-1:0]   qy,
	input  logic signed [Q_W-1:0]   qz,
	input  logic signed [Q_W-1:0]   qw,
	input  logic [THR_W-1:0]        thr,
	output logic                    out_valid,
	output logic [S_W-1:0]          num,
	output logic [S_W-1:0]          den,
	output side_t                   side
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// stage 1: products
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [31:0] yz_s1, wx_s1, wz_s1, xy_s1, wy_s1, xz_s1;
	logic signed [Q_W-1:0] y_s1, w_s1;

	// stage 2: sums
	logic [S_W-1:0]          s_s2;
	logic signed [T_W-1:0]   t_s2;
	logic signed [ARG_W-1:0] ry_s2, rx_s2, yy_s2, yx_s2;
	logic signed [Q_W-1:0]   y_s2, w_s2;

	// stage 3: pole test operands
	logic signed [46:0]      lhs_s3;
	logic [47:0]             rhs_s3;
	logic [S_W-1:0]          s_s3, num_s3;
	logic                    tneg_s3;
	logic signed [ARG_W-1:0] ry_s3, rx_s3, yy_s3, yx_s3;
	logic signed [Q_W-1:0]   y_s3, w_s3;

	logic signed [33:0]    sum4;
	logic signed [33:0]    dr, dy, rx_c, yx_c;
	logic signed [T_W-1:0] abs_t;
	logic signed [49:0]    lhs_e, rhs_e;
	logic                  north, south, zero;
	side_t                 side_c;

	assign sum4 = 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1) + 34'(ww_s1);
	assign dr   = 34'(wz_s1) - 34'(xy_s1);
	assign dy   = 34'(wy_s1) - 34'(xz_s1);
	assign rx_c = 34'(yy_s1) + 34'(ww_s1) - 34'(zz_s1) - 34'(xx_s1);
	assign yx_c = 34'(zz_s1) + 34'(ww_s1) - 34'(yy_s1) - 34'(xx_s1);

	assign abs_t = t_s2[T_W-1] ? -t_s2 : t_s2;

	assign lhs_e = {{3{lhs_s3[46]}}, lhs_s3};
	assign rhs_e = {2'b00, rhs_s3};
	assign zero  = (s_s3 == '0);
	assign north = !zero && (lhs_e > rhs_e);
	assign south = !zero && (lhs_e < -rhs_e);

	always_comb begin
		side_c.tag.zero = zero;
		side_c.t_neg    = tneg_s3;
		side_c.yaw_y    = CW'(yy_s3);
		side_c.yaw_x    = CW'(yx_s3);
		if (north || south) begin
			side_c.roll_y = CW'(y_s3);
			side_c.roll_x = CW'(w_s3);
		end else begin
			side_c.roll_y = CW'(ry_s3);
			side_c.roll_x = CW'(rx_s3);
		end
		priority if (north)
			side_c.tag.pole = POLE_NORTH;
		else if (south)
			side_c.tag.pole = POLE_SOUTH;
		else
			side_c.tag.pole = POLE_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			ww_s1 <= qw * qw;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			wy_s1 <= qw * qy;
			xz_s1 <= qx * qz;
			y_s1  <= qy;
			w_s1  <= qw;

			s_s2  <= sum4[S_W-1:0];
			t_s2  <= 33'(yz_s1) + 33'(wx_s1);
			ry_s2 <= dr <<< 1;
			yy_s2 <= dy <<< 1;
			rx_s2 <= rx_c;
			yx_s2 <= yx_c;
			y_s2  <= y_s1;
			w_s2  <= w_s1;

			lhs_s3  <= 47'(t_s2) <<< 14;
			rhs_s3  <= 48'(thr) * 48'(s_s2);
			s_s3    <= s_s2;
			num_s3  <= {abs_t[S_W-2:0], 1'b0};
			tneg_s3 <= t_s2[T_W-1];
			ry_s3   <= ry_s2;
			rx_s3   <= rx_s2;
			yy_s3   <= yy_s2;
			yx_s3   <= yx_s2;
			y_s3    <= y_s2;
			w_s3    <= w_s2;

			num  <= num_s3;
			den  <= s_s3;
			side <= side_c;
		end
	end

	assign out_valid = vld_s4;

endmodule

@@ sv/qte_div.sv @@
// ----------------------------------------------------------------------------
// qte_div
// Pipelined restoring divider, one quotient bit per stage:
// quo = floor(num * 2^30 / den) for num <= den.
// ----------------------------------------------------------------------------
module qte_div import qte_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [S_W-1:0]      num,
	input  logic [S_W-1:0]      den,
	input  side_t               side_in,
	output logic                out_valid,
	output logic [DIV_BITS-1:0] quo,
	output side_t               side_out
);

	localparam int RW = S_W + 1;

	logic [DIV_BITS-1:0] vld_s;
	logic [RW-1:0]       rem_s  [DIV_BITS];
	logic [S_W-1:0]      den_s  [DIV_BITS];
	logic [DIV_BITS-1:0] quo_s  [DIV_BITS];
	side_t               side_s [DIV_BITS];

	logic [RW-1:0]       rem_in [DIV_BITS];
	logic [RW-1:0]       rem_nx [DIV_BITS];
	logic [S_W-1:0]      d_in   [DIV_BITS];
	logic [DIV_BITS-1:0] take;

	always_comb begin
		rem_in[0] = RW'(num);
		d_in[0]   = den;
		for (int k = 1; k < DIV_BITS; k++) begin
			rem_in[k] = {rem_s[k-1][RW-2:0], 1'b0};
			d_in[k]   = den_s[k-1];
		end
		for (int k = 0; k < DIV_BITS; k++) begin
			take[k]   = rem_in[k] >= {1'b0, d_in[k]};
			rem_nx[k] = take[k] ? rem_in[k] - {1'b0, d_in[k]} : rem_in[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[DIV_BITS-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= rem_nx[0];
			den_s[0]  <= den;
			quo_s[0]  <= DIV_BITS'(take[0]);
			side_s[0] <= side_in;
			for (int k = 1; k < DIV_BITS; k++) begin
				rem_s[k]  <= rem_nx[k];
				den_s[k]  <= den_s[k-1];
				quo_s[k]  <= {quo_s[k-1][DIV_BITS-2:0], take[k]};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[DIV_BITS-1];
	assign quo       = quo_s[DIV_BITS-1];
	assign side_out  = side_s[DIV_BITS-1];

endmodule

@@ sv/qte_sqrt.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt
// Cosine term for the arcsine: c = floor(sqrt(2^60 - v*v)).
// Square, subtract, then one result bit per stage.
// ----------------------------------------------------------------------------
module qte_sqrt import qte_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [DIV_BITS-1:0] v_in,
	input  side_t               side_in,
	output logic                out_valid,
	output logic [DIV_BITS-1:0] v_out,
	output logic [ACC_FRAC:0]   c_out,
	output side_t               side_out
);

	logic                vld_s1, vld_s2;
	logic [NW-1:0]       vsq_s1, n_s2;
	logic [DIV_BITS-1:0] v_s1, v_s2;
	side_t               side_s1, side_s2;

	logic [SQRT_STEPS-1:0] vld_s;
	logic [NW-1:0]         rad_s  [SQRT_STEPS];
	logic [NW-1:0]         res_s  [SQRT_STEPS];
	logic [DIV_BITS-1:0]   v_s    [SQRT_STEPS];
	side_t                 side_s [SQRT_STEPS];

	logic [NW-1:0] rad_in [SQRT_STEPS];
	logic [NW-1:0] res_in [SQRT_STEPS];
	logic [NW-1:0] rad_nx [SQRT_STEPS];
	logic [NW-1:0] res_nx [SQRT_STEPS];

	always_comb begin
		logic [NW-1:0] bitv;
		logic [NW-1:0] trial;
		rad_in[0] = n_s2;
		res_in[0] = '0;
		for (int k = 1; k < SQRT_STEPS; k++) begin
			rad_in[k] = rad_s[k-1];
			res_in[k] = res_s[k-1];
		end
		for (int k = 0; k < SQRT_STEPS; k++) begin
			bitv  = NW'(1) << (2 * (ACC_FRAC - k));
			trial = res_in[k] + bitv;
			if (rad_in[k] >= trial) begin
				rad_nx[k] = rad_in[k] - trial;
				res_nx[k] = (res_in[k] >> 1) + bitv;
			end else begin
				rad_nx[k] = rad_in[k];
				res_nx[k] = res_in[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s  <= '0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s  <= {vld_s[SQRT_STEPS-2:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vsq_s1  <= NW'(v_in) * NW'(v_in);
			v_s1    <= v_in;
			side_s1 <= side_in;
			n_s2    <= (NW'(1) << (2 * ACC_FRAC)) - vsq_s1;
			v_s2    <= v_s1;
			side_s2 <= side_s1;
			rad_s[0]  <= rad_nx[0];
			res_s[0]  <= res_nx[0];
			v_s[0]    <= v_s2;
			side_s[0] <= side_s2;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				rad_s[k]  <= rad_nx[k];
				res_s[k]  <= res_nx[k];
				v_s[k]    <= v_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS-1];
	assign v_out     = v_s[SQRT_STEPS-1];
	assign c_out     = res_s[SQRT_STEPS-1][ACC_FRAC:0];
	assign side_out  = side_s[SQRT_STEPS-1];

endmodule

@@ sv/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC, atan2(y, x) with 30 fraction bits.
// Quarter-turn pre-rotation stage, then one micro-rotation per stage.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] x_in,
	input  tag_t                 tag_in,
	output logic                 out_valid,
	output logic signed [AW-1:0] angle,
	output tag_t                 tag_out
);

	localparam int NS = CORDIC_STEPS + 1;

	logic [NS-1:0]        vld_s;
	logic signed [CW-1:0] x_s   [NS];
	logic signed [CW-1:0] y_s   [NS];
	logic signed [AW-1:0] z_s   [NS];
	logic [NS-1:0]        zf_s;
	tag_t                 tag_s [NS];

	logic signed [CW-1:0] x_pre, y_pre;
	logic signed [AW-1:0] z_pre;
	logic signed [CW-1:0] x_nx [CORDIC_STEPS];
	logic signed [CW-1:0] y_nx [CORDIC_STEPS];
	logic signed [AW-1:0] z_nx [CORDIC_STEPS];

	always_comb begin
		x_pre = x_in;
		y_pre = y_in;
		z_pre = '0;
		if (x_in[CW-1]) begin
			if (!y_in[CW-1]) begin
				x_pre = y_in;
				y_pre = -x_in;
				z_pre = HALF_PI_ACC;
			end else begin
				x_pre = -y_in;
				y_pre = x_in;
				z_pre = -HALF_PI_ACC;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (!y_s[i][CW-1]) begin
				x_nx[i] = x_s[i] + (y_s[i] >>> i);
				y_nx[i] = y_s[i] - (x_s[i] >>> i);
				z_nx[i] = z_s[i] + atan_entry(i);
			end else begin
				x_nx[i] = x_s[i] - (y_s[i] >>> i);
				y_nx[i] = y_s[i] + (x_s[i] >>> i);
				z_nx[i] = z_s[i] - atan_entry(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NS-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= x_pre;
			y_s[0]   <= y_pre;
			z_s[0]   <= z_pre;
			zf_s[0]  <= (x_in == '0) && (y_in == '0);
			tag_s[0] <= tag_in;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				x_s[i+1]   <= x_nx[i];
				y_s[i+1]   <= y_nx[i];
				z_s[i+1]   <= z_nx[i];
				zf_s[i+1]  <= zf_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign angle     = zf_s[NS-1] ? '0 : z_s[NS-1];
	assign tag_out   = tag_s[NS-1];

endmodule

@@ dv/quaternion_to_euler_test.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_test
// Streams quaternions through the converter under several threshold settings
// and idle/stall patterns; a scoreboard predicts pitch/yaw/roll and pole case
// with its own CORDIC, divider and square root and checks every result.
// ----------------------------------------------------------------------------

class euler_scoreboard;
	logic [14:0] threshold;
	logic [57:0] angles_due[$];   // {pole, pad, roll, yaw, pitch}
	int errors;

	function new();
		threshold = qte_pkg::THR_RESET;
		errors = 0;
	endfunction

	static function longint fshift(longint v, int k);
		return v >>> k;
	endfunction

	static function longint arc_tangent(longint y, longint x);
		longint z, nx, ny, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				nx = y; ny = -x; z = 64'sd1686629713;
			end else begin
				nx = -y; ny = x; z = -64'sd1686629713;
			end
			x = nx; y = ny;
		end
		for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin
			xs = fshift(x, i);
			ys = fshift(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += longint'(qte_pkg::atan_entry(i));
			end else begin
				x = x - ys; y = y + xs; z -= longint'(qte_pkg::atan_entry(i));
			end
		end
		return z;
	endfunction

	static function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	static function logic [16:0] scale_angle(longint a);
		longint r;
		r = (a + (64'sd1 << 16)) >>> 17;
		if (r > 65535) r = 65535;
		if (r < -65536) r = -65536;
		return r[16:0];
	endfunction

	function void note_quaternion(logic [63:0] q);
		longint x, y, z, w, s, t, lhs, rhs, p, yw, rl, sv;
		longint unsigned at, v, c;
		logic [1:0] pole;
		x = longint'($signed(q[15:0]));
		y = longint'($signed(q[31:16]));
		z = longint'($signed(q[47:32]));
		w = longint'($signed(q[63:48]));
		s = x*x + y*y + z*z + w*w;
		t = y*z + w*x;
		lhs = t * 16384;
		rhs = longint'(threshold) * s;
		if (s == 0) begin
			angles_due.push_back('0);
			return;
		end
		if (lhs > rhs) begin
			rl = 2 * arc_tangent(y, w); p = 64'sd1686629713; yw = 0;
			pole = qte_pkg::POLE_NORTH;
		end else if (lhs < -rhs) begin
			rl = -2 * arc_tangent(y, w); p = -64'sd1686629713; yw = 0;
			pole = qte_pkg::POLE_SOUTH;
		end else begin
			at = t < 0 ? -t : t;
			v = ((2 * at) << 30) / s;
			if (v > (64'd1 << 30)) v = 64'd1 << 30;
			c = int_sqrt((64'd1 << 60) - v * v);
			sv = t < 0 ? -longint'(v) : longint'(v);
			p = arc_tangent(sv, longint'(c));
			rl = arc_tangent(2 * (w*z - x*y), s - 2 * (z*z + x*x));
			yw = arc_tangent(2 * (w*y - x*z), s - 2 * (y*y + x*x));
			pole = qte_pkg::POLE_NONE;
		end
		angles_due.push_back({pole, 5'd0, scale_angle(rl), scale_angle(yw),
			scale_angle(p)});
	endfunction

	function void check_angles(logic [55:0] d, logic [1:0] u);
		logic [57:0] e;
		if (angles_due.size() == 0) begin
			$display("%0t: unexpected transaction tdata=%h tuser=%0d", $time, d, u);
			errors++;
			return;
		end
		e = angles_due.pop_front();
		if (d[16:0] !== e[16:0]) begin
			$display("%0t: pitch expected %h actual %h", $time, e[16:0], d[16:0]);
			errors++;
		end
		if (d[33:17] !== e[33:17]) begin
			$display("%0t: yaw expected %h actual %h", $time, e[33:17], d[33:17]);
			errors++;
		end
		if (d[50:34] !== e[50:34]) begin
			$display("%0t: roll expected %h actual %h", $time, e[50:34], d[50:34]);
			errors++;
		end
		if (d[55:51] !== 5'd0) begin
			$display("%0t: pad expected 0 actual %h", $time, d[55:51]);
			errors++;
		end
		if (u !== e[57:56]) begin
			$display("%0t: pole expected %0d actual %0d", $time, e[57:56], u);
			errors++;
		end
	endfunction
endclass

module quaternion_to_euler_test;
	import qte_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [55:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 0;
	logic [THR_W-1:0] cfg_wdata = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	euler_scoreboard sb = new();

	quaternion_to_euler uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// receiver side: check, then pick next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_angles(m_tdata, m_tuser);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// tvalid stays high after an accept; idle cycles or drain() drop it
	task automatic send_quaternion(logic [63:0] q);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= q;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_quaternion(q);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.angles_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.threshold = v;
		cfg_we <= 0;
	endtask

	function automatic logic [15:0] comp(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(32767)) - 16384);
			default: return 16'($signed($urandom_range(2048)) - 1024);
		endcase
	endfunction

	// random quaternions; some have two components near +/-11585 and two small
	task automatic send_random();
		logic [15:0] a, b;
		int m;
		m = $urandom_range(9);
		if (m < 2) begin
			a = comp(2);
			b = comp(2);
			send_quaternion({16'(11585 + $signed(a) / 8), 16'(11585 + $signed(b) / 8),
				a, b});
		end else if (m == 2) begin
			a = comp(2);
			send_quaternion({16'(-11585), a, 16'(-11585), comp(2)});
		end else
			send_quaternion({comp(m > 7 ? 0 : 1), comp(m > 7 ? 0 : 1),
				comp(m > 7 ? 0 : 1), comp(m > 7 ? 0 : 1)});
	endtask

	initial begin
		logic [14:0] thr_set[5];
		int pct[4][2];
		thr_set = '{15'd8176, 15'd0, 15'd16384, 15'd32767, 15'd8000};
		pct = '{'{0, 0}, '{86, 0}, '{0, 86}, '{21, 21}};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, zero, both poles, degenerate atan2
		send_quaternion(64'd0);
		send_quaternion({16'h4000, 16'd0, 16'd0, 16'd0});
		send_quaternion({16'd0, 16'd0, 16'd0, 16'h4000});
		send_quaternion({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
		send_quaternion({16'h8000, 16'h8000, 16'h8000, 16'h8000});
		send_quaternion({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
		send_quaternion({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
		send_quaternion({16'd11585, 16'd0, 16'd0, 16'd11585});
		send_quaternion({16'd11585, 16'd0, 16'd0, 16'(-11585)});
		send_quaternion({16'(-11585), 16'd0, 16'd0, 16'd11585});
		send_quaternion({16'd11585, 16'd11585, 16'd0, 16'd0});
		send_quaternion({16'd0, 16'd0, 16'h4000, 16'd0});
		send_quaternion({16'd0, 16'h4000, 16'd0, 16'd0});
		send_quaternion({16'h0001, 16'hffff, 16'h0001, 16'hffff});
		send_quaternion({16'd8192, 16'd8192, 16'd8192, 16'd8192});
		send_quaternion({16'd8192, 16'(-8192), 16'd8192, 16'd8192});
		send_quaternion({16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(thr_set[ph]);
			for (int k = 0; k < 4; k++) begin
				send_idle_pct = pct[(ph + k) % 4][0];
				recv_stall_pct = pct[(ph + k) % 4][1];
				repeat (27) send_random();
			end
			drain();
		end

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
sv/qte_pkg.sv
sv/qte_front.sv
sv/qte_div.sv
sv/qte_sqrt.sv
sv/qte_cordic.sv
sv/quaternion_to_euler.sv
dv/quaternion_to_euler_test.sv
